### hdl/assert_macros.svh
// Assertion macros shared by the lock finder RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/llrf_pkg.sv
// Shared constants and types for the LFSR lock longest-run finder.
// No dependencies; imported by llrf_div and lfsr_lock_longest_run_finder.
package llrf_pkg;

    localparam int DATA_W     = 8;
    localparam int SHIFT_W    = 32;
    localparam int OUT_W      = 32;
    localparam int LANE_CFG_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [SHIFT_W-1:0] LFSR_TAPS = 32'h8040_1020;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LANE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED   = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_LOCK = 2'd1;
    localparam logic [1:0] ST_TOO_FEW = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

### hdl/llrf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on llrf_pkg (t_div_status) and assert_macros.svh.
`include "assert_macros.svh"

module llrf_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_W-1:0]    i_dividend,
    input  logic [DIVISOR_W-1:0]     i_divisor,
    output logic [DIVIDEND_W-1:0]    o_quotient,
    output llrf_pkg::t_div_status    o_status
);
    import llrf_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;
    logic [DIVISOR_W-1:0]  w_rem_next;

    always_comb begin
        w_trial    = {r_rem, r_quo[DIVIDEND_W-1]};
        w_diff     = w_trial - {1'b0, i_divisor};
        w_ge       = (w_trial >= {1'b0, i_divisor});
        w_rem_next = w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(DIVIDEND_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
                r_rem <= w_rem_next;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient    = r_quo;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

    `ASSERT_IMPL(a_start_when_free, i_clk, i_rst_n, i_start, !r_busy)

endmodule

### hdl/lfsr_lock_longest_run_finder.sv
// Top level of the LFSR lock longest-run finder: lane sequencer, lane store,
// result register. Depends on llrf_pkg, llrf_div and assert_macros.svh.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_ready | i_data_byte, i_last_byte
//  result   | o_out_valid/i_out_ready | o_status, o_start_offset, o_sample_count
//  config   | i_cfg_we                | i_cfg_index, i_cfg_data
//
// An ordinary byte first reads its lane from the lane store, then checks the
// prediction and writes the lane back.
// On the last byte of a buffer, S_CHECK tests for a lock; when one is found,
// the bit-serial divider turns the best run into a sample count before S_OUT;
// without a lock it goes straight to S_OUT.
// Reset is synchronous; lane state needs no clearing pass (per-lane valid bits).
// A held result does not block input; only a second result waiting on it does.
`include "assert_macros.svh"

module lfsr_lock_longest_run_finder #(
    parameter int MAX_LANES     = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [llrf_pkg::DATA_W-1:0]         i_data_byte,
    input  logic                                i_last_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic [llrf_pkg::OUT_W-1:0]          o_start_offset,
    output logic [llrf_pkg::OUT_W-1:0]          o_sample_count,
    input  logic                                i_cfg_we,
    input  logic [llrf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [llrf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import llrf_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int LW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int NW = $clog2(MAX_LANES + 1);
    localparam int WW = (PB > OUT_W) ? PB : OUT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_DIV,
        S_OUT
    } t_state;

    t_state                 r_state;
    logic [LANE_CFG_W-1:0]  r_lane_count;
    logic [OUT_W-1:0]       r_required;

    // lane store
    logic [SHIFT_W-1:0]     r_mem_shift [MAX_LANES];
    logic [PB-1:0]          r_mem_bad   [MAX_LANES];
    logic [MAX_LANES-1:0]   r_lane_vld;
    logic [SHIFT_W-1:0]     r_rd_shift;
    logic [PB-1:0]          r_rd_bad;
    logic                   r_rd_vld;

    logic [LW-1:0]          r_lane_ptr;
    logic [LW-1:0]          r_lane;
    logic                   r_bit;
    logic                   r_last;
    logic [PB-1:0]          r_pos;
    logic [PB-1:0]          r_best_len;
    logic [PB-1:0]          r_best_start;
    logic [PB-1:0]          r_fin_len;
    logic [PB-1:0]          r_fin_start;
    logic                   r_nolock;

    logic                   r_out_valid;
    logic [1:0]             r_status;
    logic [OUT_W-1:0]       r_start_off;
    logic [OUT_W-1:0]       r_sample_cnt;

    logic [PB-1:0]          n_best_len;
    logic [PB-1:0]          n_best_start;

    logic                   w_accept;
    logic [NW-1:0]          w_n;
    logic [PB-1:0]          w_n_pb;
    logic [PB-1:0]          w_n64;
    logic [PB-1:0]          w_n63;
    logic [PB-1:0]          w_n31;
    logic [LW-1:0]          w_lane;
    logic [NW-1:0]          w_lane_inc;
    logic [LW-1:0]          w_next_ptr;
    logic [SHIFT_W-1:0]     w_shift_cur;
    logic [PB-1:0]          w_bad_cur;
    logic                   w_pred;
    logic [SHIFT_W-1:0]     w_shifted;
    logic                   w_fail;
    logic [PB-1:0]          w_run;
    logic                   w_better;
    logic [PB-1:0]          w_bad_new;
    logic                   w_mem_we;
    logic                   w_lock;
    logic                   w_div_start;
    logic [PB-1:0]          w_dividend;
    logic [PB-1:0]          w_quo;
    t_div_status            w_div_sts;
    logic [WW-1:0]          w_quo_w;
    logic [WW-1:0]          w_req_w;
    logic [WW-1:0]          w_start_w;
    logic                   w_out_free;
    logic                   w_out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_mem_we   = (r_state == S_EVAL);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = (r_state == S_OUT) && w_out_free;

    // effective lane count and its small multiples
    always_comb begin
        if (r_lane_count == '0) begin
            w_n = NW'(1);
        end else if (32'(r_lane_count) > MAX_LANES) begin
            w_n = NW'(MAX_LANES);
        end else begin
            w_n = NW'(r_lane_count);
        end
        w_n_pb = PB'(w_n);
        w_n64  = w_n_pb << 6;
        w_n63  = w_n64 - w_n_pb;
        w_n31  = (w_n_pb << 5) - w_n_pb;
    end

    always_comb begin
        w_lane     = (NW'(r_lane_ptr) >= w_n) ? '0 : r_lane_ptr;
        w_lane_inc = NW'(r_lane) + NW'(1);
        w_next_ptr = (w_lane_inc >= w_n) ? '0 : LW'(w_lane_inc);
    end

    // lane check: a lane never written reads as its reset value
    always_comb begin
        w_shift_cur  = r_rd_vld ? r_rd_shift : '0;
        w_bad_cur    = r_rd_vld ? r_rd_bad : PB'(r_lane);
        w_pred       = ^(w_shift_cur & LFSR_TAPS);
        w_shifted    = {w_shift_cur[SHIFT_W-2:0], r_bit};
        w_fail       = (w_pred != r_bit) || (w_shifted == '0);
        w_run        = r_pos - w_bad_cur;
        w_better     = !w_fail && (w_run >= r_best_len);
        w_bad_new    = w_fail ? r_pos : w_bad_cur;
        n_best_len   = w_better ? w_run : r_best_len;
        n_best_start = w_better ? w_bad_cur : r_best_start;
    end

    always_comb begin
        w_lock      = (r_fin_len >= w_n64);
        w_div_start = (r_state == S_CHECK) && w_lock;
        w_dividend  = r_fin_len - w_n63;
        w_quo_w     = WW'(w_quo);
        w_req_w     = WW'(r_required);
        w_start_w   = WW'(r_fin_start);
    end

    llrf_div #(
        .DIVIDEND_W (PB),
        .DIVISOR_W  (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_n),
        .o_quotient (w_quo),
        .o_status   (w_div_sts)
    );

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem_shift[r_lane] <= w_shifted;
            r_mem_bad[r_lane]   <= w_bad_new;
        end
        if (w_accept) begin
            r_rd_shift <= r_mem_shift[w_lane];
            r_rd_bad   <= r_mem_bad[w_lane];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_lane_count <= LANE_CFG_W'(1);
            r_required   <= '0;
            r_lane_vld   <= '0;
            r_rd_vld     <= 1'b0;
            r_lane_ptr   <= '0;
            r_pos        <= '0;
            r_best_len   <= '0;
            r_best_start <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LANE_COUNT: r_lane_count <= i_cfg_data[LANE_CFG_W-1:0];
                    CFG_REQUIRED:   r_required   <= i_cfg_data[OUT_W-1:0];
                    default:        ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_lane   <= w_lane;
                        r_bit    <= i_data_byte[DATA_W-1];
                        r_last   <= i_last_byte;
                        r_rd_vld <= r_lane_vld[w_lane];
                        r_state  <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_last) begin
                        // capture the best run, then start a fresh buffer
                        r_fin_len    <= n_best_len;
                        r_fin_start  <= n_best_start;
                        r_lane_vld   <= '0;
                        r_lane_ptr   <= '0;
                        r_pos        <= '0;
                        r_best_len   <= '0;
                        r_best_start <= '0;
                        r_state      <= S_CHECK;
                    end else begin
                        r_lane_vld[r_lane] <= 1'b1;
                        r_lane_ptr         <= w_next_ptr;
                        r_pos              <= r_pos + PB'(1);
                        r_best_len         <= n_best_len;
                        r_best_start       <= n_best_start;
                        r_state            <= S_IDLE;
                    end
                end
                S_CHECK: begin
                    if (w_lock) begin
                        r_nolock    <= 1'b0;
                        r_fin_start <= r_fin_start + w_n31 + PB'(1);
                        r_state     <= S_DIV;
                    end else begin
                        r_nolock <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_div_sts.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the previous result is taken
                    if (w_out_load) begin
                        if (r_nolock) begin
                            r_status     <= ST_NO_LOCK;
                            r_start_off  <= '0;
                            r_sample_cnt <= '0;
                        end else begin
                            r_status     <= (w_quo_w < w_req_w) ? ST_TOO_FEW : ST_OK;
                            r_start_off  <= w_start_w[OUT_W-1:0];
                            r_sample_cnt <= w_quo_w[OUT_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_start_offset = r_start_off;
    assign o_sample_count = r_sample_cnt;

    `ASSERT_NEXT(a_last_clears_stream, i_clk, i_rst_n, (r_state == S_EVAL) && r_last, (r_pos == '0) && (r_best_len == '0) && (r_lane_vld == '0))
    `ASSERT_IMPL(a_result_from_out, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_OUT)
    `ASSERT_IMPL(a_nolock_fields_zero, i_clk, i_rst_n, r_out_valid && (r_status == ST_NO_LOCK), (r_start_off == '0) && (r_sample_cnt == '0))
    `ASSERT_IMPL(a_div_running, i_clk, i_rst_n, r_state == S_DIV, |w_div_sts)

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for lfsr_lock_longest_run_finder: directed and random byte buffers
// checked against an in-bench lock tracker. Depends on llrf_pkg and the RTL top.
module tb_top;
    import llrf_pkg::*;

    localparam int MAX_LANES     = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic [1:0]       status;
        logic [OUT_W-1:0] start_offset;
        logic [OUT_W-1:0] sample_count;
    } t_lock_report;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [DATA_W-1:0]     data_byte = '0;
    logic                  last_byte = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            status;
    logic [OUT_W-1:0]      start_offset;
    logic [OUT_W-1:0]      sample_count;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Lock tracker state and its copy of the registers
    logic [LANE_CFG_W-1:0] lane_count_reg = 5'd1;
    logic [31:0]           required_reg   = '0;
    logic [SHIFT_W-1:0]    lane_sr      [MAX_LANES];
    logic [31:0]           lane_bad_pos [MAX_LANES];
    logic [31:0]           run_start;
    logic [31:0]           run_length;
    logic [31:0]           byte_pos;
    int unsigned           lane_ptr;

    t_lock_report lock_reports_q[$];
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int unsigned  errors        = 0;
    int unsigned  items_sent    = 0;
    int unsigned  reports_due   = 0;
    int unsigned  cycle_count   = 0;

    lfsr_lock_longest_run_finder i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_last_byte    (last_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_status       (status),
        .o_start_offset (start_offset),
        .o_sample_count (sample_count),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic prbs_bit(input logic [SHIFT_W-1:0] state);
        return ^(state & LFSR_TAPS);
    endfunction

    function automatic int unsigned eff_lanes();
        int unsigned n;
        n = lane_count_reg;
        if (n == 0) n = 1;
        if (n > MAX_LANES) n = MAX_LANES;
        return n;
    endfunction

    function automatic void clear_tracker();
        for (int i = 0; i < MAX_LANES; i++) begin
            lane_sr[i]      = '0;
            lane_bad_pos[i] = 32'(i);
        end
        run_start  = '0;
        run_length = '0;
        lane_ptr   = 0;
        byte_pos   = '0;
    endfunction

    // Advance the lock tracker by one accepted item; queue a report on the last byte
    task automatic track_byte(input logic [7:0] b, input logic is_last);
        int unsigned        n;
        int unsigned        lane;
        logic [SHIFT_W-1:0] shifted;
        logic [31:0]        run;
        t_lock_report       rep;
        n       = eff_lanes();
        lane    = (lane_ptr >= n) ? 0 : lane_ptr;
        shifted = {lane_sr[lane][SHIFT_W-2:0], b[7]};
        if (prbs_bit(lane_sr[lane]) != b[7] || shifted == '0) begin
            lane_bad_pos[lane] = byte_pos;
        end else begin
            run = byte_pos - lane_bad_pos[lane];
            if (run >= run_length) begin
                run_start  = lane_bad_pos[lane];
                run_length = run;
            end
        end
        lane_sr[lane] = shifted;
        lane_ptr      = (lane + 1 >= n) ? 0 : lane + 1;
        byte_pos      = byte_pos + 1;
        if (is_last) begin
            if (run_length < 32'(64 * n)) begin
                rep = '{ST_NO_LOCK, '0, '0};
            end else begin
                rep.sample_count = (run_length - 32'(63 * n)) / 32'(n);
                rep.start_offset = run_start + 32'(31 * n + 1);
                rep.status       = (rep.sample_count < required_reg) ? ST_TOO_FEW : ST_OK;
            end
            lock_reports_q.push_back(rep);
            reports_due++;
            clear_tracker();
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] expd,
                                input logic [31:0] got);
        if (got !== expd) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expd, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : check_reports
        t_lock_report expd;
        if (rst_n && out_valid && out_ready) begin
            if (lock_reports_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d start %0d count %0d",
                         $time, status, start_offset, sample_count);
                errors++;
            end else begin
                expd = lock_reports_q.pop_front();
                report_field("status", 32'(expd.status), 32'(status));
                report_field("start_offset", expd.start_offset, start_offset);
                report_field("sample_count", expd.sample_count, sample_count);
            end
        end
    end

    // Draw the idle choice anew on every clock so the idle share tracks send_idle_pct
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        do @(posedge clk); while (!in_ready);
        track_byte(b, is_last);
        items_sent++;
    endtask

    // Drop valid, let all reports drain and the block finish its last item
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (lock_reports_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        settle_block();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LANE_COUNT) lane_count_reg = value[LANE_CFG_W-1:0];
        else required_reg = value;
    endtask

    // Unused upper bits of the lane count word carry random junk
    task automatic set_lanes(input logic [LANE_CFG_W-1:0] lanes);
        write_reg(CFG_LANE_COUNT, ($urandom() & 32'hFFFF_FFE0) | 32'(lanes));
    endtask

    task automatic send_noise(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    // Interleaved PRBS lanes in bit 7, random low bits, optional bit errors
    task automatic send_prbs_buffer(input int unsigned samples, input int unsigned err_permille);
        logic [SHIFT_W-1:0] seq [MAX_LANES];
        int unsigned        n;
        int unsigned        len;
        logic               bit_val;
        n   = eff_lanes();
        len = n * samples;
        for (int l = 0; l < MAX_LANES; l++) begin
            do seq[l] = $urandom(); while (seq[l] == '0);
        end
        for (int unsigned i = 0; i < len; i++) begin
            bit_val      = prbs_bit(seq[i % n]);
            seq[i % n]   = {seq[i % n][SHIFT_W-2:0], bit_val};
            if ($urandom_range(999) < err_permille) bit_val = ~bit_val;
            send_byte({bit_val, 7'($urandom())}, i == len - 1);
        end
    endtask

    task automatic test_reset_defaults();
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_all_zero_stream();
        repeat (3) send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_byte_extremes();
        write_reg(CFG_REQUIRED, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hAA, 1'b1);
    endtask

    task automatic test_lane_count_zero();
        write_reg(CFG_LANE_COUNT, 32'hFFFF_FFE0);
        write_reg(CFG_REQUIRED, 32'h0000_0000);
        send_noise(3);
    endtask

    task automatic test_lane_count_saturation();
        write_reg(CFG_LANE_COUNT, 32'h0000_001F);
        send_noise(4);
    endtask

    // Shrink the lane count while the lane pointer sits at or above the new count
    task automatic test_lane_change_mid_buffer();
        set_lanes(5'd4);
        repeat (6) send_byte(8'($urandom_range(255)), 1'b0);
        set_lanes(5'd2);
        send_noise(3);
    endtask

    task automatic pick_setting();
        logic [LANE_CFG_W-1:0] lanes;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: lanes = 5'($urandom_range(3, 1));
            6:                lanes = 5'd0;
            7:                lanes = 5'($urandom_range(8, 4));
            8:                lanes = 5'($urandom_range(16, 9));
            default:          lanes = 5'($urandom_range(31, 17));
        endcase
        set_lanes(lanes);
        case ($urandom_range(3))
            0:       write_reg(CFG_REQUIRED, 32'h0000_0000);
            1:       write_reg(CFG_REQUIRED, 32'($urandom_range(150)));
            2:       write_reg(CFG_REQUIRED, 32'hFFFF_FFFF);
            default: write_reg(CFG_REQUIRED, $urandom());
        endcase
    endtask

    task automatic send_random_buffer();
        int unsigned n;
        int unsigned err;
        n   = eff_lanes();
        err = ($urandom_range(1) == 0) ? 0 : $urandom_range(20, 1);
        case ($urandom_range(9))
            0, 1, 2, 3: send_noise($urandom_range(40, 1));
            4:          send_prbs_buffer($urandom_range(n <= 4 ? 60 : 12, 4),
                                         $urandom_range(50, 5));
            default: begin
                if (n <= 4) send_prbs_buffer($urandom_range(200, 70), err);
                else if ($urandom_range(3) == 0) send_prbs_buffer($urandom_range(120, 100), err);
                else send_noise($urandom_range(40, 1));
            end
        endcase
    endtask

    task automatic test_random_buffers(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned item_goal,
                                       input int unsigned report_goal);
        int unsigned items0;
        int unsigned reports0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        items0        = items_sent;
        reports0      = reports_due;
        while (items_sent - items0 < item_goal || reports_due - reports0 < report_goal) begin
            pick_setting();
            repeat ($urandom_range(5, 2)) begin
                if (items_sent - items0 < item_goal || reports_due - reports0 < report_goal)
                    send_random_buffer();
            end
        end
    endtask

    initial begin
        clear_tracker();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_all_zero_stream();
        test_byte_extremes();
        test_lane_count_zero();
        test_lane_count_saturation();
        test_lane_change_mid_buffer();
        test_random_buffers(29, 85, 650, 4);
        test_random_buffers(85, 29, 650, 4);
        test_random_buffers(0, 0, 600, 4);

        settle_block();
        if (errors == 0 && lock_reports_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/llrf_pkg.sv
hdl/llrf_div.sv
hdl/lfsr_lock_longest_run_finder.sv
sim/tb_top.sv
